// File: sv/gpl_pkg.sv
// gpl_pkg: shared types, constants and elaboration-time tables for the gamma transform
// no dependencies; used by gpl_exp2 and gamma_power_law_transform_top
`default_nettype none

package gpl_pkg;

	localparam int PIX_W   = 8;
	localparam int GAIN_W  = 12;
	localparam int GAMMA_W = 10;
	localparam int LOG_W   = 20;
	localparam int P_W     = 23;
	localparam int FRAC_W  = 16;
	localparam int Q_W     = 31;
	localparam int HI_W    = 8;
	localparam int LO_W    = FRAC_W - HI_W;
	localparam int GP_W    = GAIN_W + Q_W;
	localparam int SH_W    = GP_W + 7;
	localparam int V_W     = SH_W - 30;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [PIX_W-1:0]   PIX_MAX     = 8'd255;
	localparam logic [GAIN_W-1:0]  GAIN_RST    = 12'd1;
	localparam logic [GAMMA_W-1:0] GAMMA_RST   = 10'd256;
	localparam logic [P_W-1:0]     P_ROUND     = 23'd128;
	localparam logic [SH_W-1:0]    FINAL_BIAS  = SH_W'(64'd1 << 24);

	// register select is paddr[2]
	typedef enum logic {
		REG_GAIN  = 1'b0,
		REG_GAMMA = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic       zero;
		logic       big;
		logic [2:0] shift;
	} side_t;

	typedef logic [255:0][LOG_W-1:0] log_tab_t;
	typedef logic [16:1][Q_W-1:0]    exp_c_t;
	typedef logic [255:0][Q_W-1:0]   exp_tab_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = '0;
		b   = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic log_tab_t build_log2_tab();
		log_tab_t    tab;
		logic [63:0] m;
		logic [63:0] frac;
		int          n;
		int          x;
		int          i;
		tab = '0;
		for (x = 1; x < 256; x++) begin
			n = 0;
			while (n < 7 && (x >> (n + 1)) != 0)
				n++;
			m    = 64'(x) << (30 - n);
			frac = '0;
			for (i = 0; i < 17; i++) begin
				m    = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (64'd1 << 31)) begin
					frac = frac | 64'd1;
					m    = m >> 1;
				end
			end
			tab[x] = LOG_W'((64'(n) << 16) + ((frac + 64'd1) >> 1));
		end
		return tab;
	endfunction

	function automatic exp_c_t build_exp_c();
		exp_c_t      cs;
		logic [63:0] c;
		int          k;
		c = 64'd2 << 30;
		for (k = 1; k <= 16; k++) begin
			c     = isqrt64(c << 30);
			cs[k] = Q_W'(c);
		end
		return cs;
	endfunction

	localparam exp_c_t EXP_C = build_exp_c();

	// 2^(b/256) for the upper fraction byte, same truncation order as the serial form
	function automatic exp_tab_t build_exp_hi_tab();
		exp_tab_t    tab;
		logic [63:0] r;
		int          b;
		int          k;
		for (b = 0; b < 256; b++) begin
			r = 64'd1 << 30;
			for (k = 1; k <= HI_W; k++) begin
				if (((b >> (HI_W - k)) & 1) != 0)
					r = (r * 64'(EXP_C[k])) >> 30;
			end
			tab[b] = Q_W'(r);
		end
		return tab;
	endfunction

	localparam log_tab_t LOG2_TAB   = build_log2_tab();
	localparam exp_tab_t EXP_HI_TAB = build_exp_hi_tab();

endpackage

`default_nettype wire

// File: sv/gamma_power_law_transform_top.sv
// gamma_power_law_transform_top: pixel_out = min(255, floor(gain * x^gamma + 1/64))
// log2 table, exponent multiply, gpl_exp2, gain multiply, shift and saturate; uses gpl_pkg
//
//   port group   direction  handshake            payload
//   pixel in     in         in_valid/in_stall    pixel_in[7:0]
//   pixel out    out        out_valid/out_stall  pixel_out[7:0]
//   registers    in/out     apb psel/penable     gain @0x0, gamma_q8 @0x4
//
// 13 register stages: log lookup, exponent multiply, fraction table, eight fraction
// multiplies, gain multiply, shift/round/saturate; one pixel per cycle while out_stall is low
// each stage moves when it is empty or the next one moves, so bubbles close under a stall
// reset empties the pipeline and loads gain = 1, gamma_q8 = 1.0; no clearing pass
`default_nettype none

module gamma_power_law_transform_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [gpl_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [gpl_pkg::DATA_W-1:0]    pwdata,
	output logic      [gpl_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [gpl_pkg::PIX_W-1:0]     pixel_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [gpl_pkg::PIX_W-1:0]     pixel_out
);

	logic [gpl_pkg::GAIN_W-1:0]  gain_q;
	logic [gpl_pkg::GAMMA_W-1:0] gamma_q8_q;
	gpl_pkg::reg_sel_t           sel;

	logic                        valid_s1, valid_s2, valid_s12, valid_s13;
	logic [gpl_pkg::LOG_W-1:0]   log_s1;
	logic                        zero_s1;
	logic [gpl_pkg::FRAC_W-1:0]  frac_s2;
	gpl_pkg::side_t              side_s2, side_s12;
	logic [gpl_pkg::GP_W-1:0]    gp_s12;
	logic [gpl_pkg::PIX_W-1:0]   pix_s13;

	logic                        en_s1, en_s2, en_s12, en_s13;
	logic                        ex_stall, ex_valid;
	logic [gpl_pkg::Q_W-1:0]     ex_r;
	gpl_pkg::side_t              ex_side;

	logic [gpl_pkg::P_W+7:0]     p_full;
	logic [gpl_pkg::P_W-1:0]     p;
	gpl_pkg::side_t              side_nxt;
	logic [gpl_pkg::SH_W-1:0]    sh;
	logic [gpl_pkg::V_W-1:0]     v;
	logic [gpl_pkg::PIX_W-1:0]   pix_nxt;

	// register port
	assign sel    = gpl_pkg::reg_sel_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= gpl_pkg::GAIN_RST;
			gamma_q8_q <= gpl_pkg::GAMMA_RST;
		end else if (psel && penable && pwrite) begin
			unique case (sel)
				gpl_pkg::REG_GAIN:  gain_q     <= pwdata[gpl_pkg::GAIN_W-1:0];
				gpl_pkg::REG_GAMMA: gamma_q8_q <= pwdata[gpl_pkg::GAMMA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			gpl_pkg::REG_GAIN:  prdata = gpl_pkg::DATA_W'(gain_q);
			gpl_pkg::REG_GAMMA: prdata = gpl_pkg::DATA_W'(gamma_q8_q);
			default:            prdata = '0;
		endcase
	end

	// stage enables
	assign en_s13   = !valid_s13 || !out_stall;
	assign en_s12   = !valid_s12 || en_s13;
	assign en_s2    = !valid_s2 || !ex_stall;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// exponent
	always_comb begin
		p_full         = (gpl_pkg::P_W+8)'(gamma_q8_q) * (gpl_pkg::P_W+8)'(log_s1)
			+ (gpl_pkg::P_W+8)'(gpl_pkg::P_ROUND);
		p              = p_full[gpl_pkg::P_W+7:8];
		side_nxt.zero  = zero_s1;
		side_nxt.big   = |p[gpl_pkg::P_W-1:19];
		side_nxt.shift = p[18:16];
	end

	// shift, round, saturate
	always_comb begin
		sh = (gpl_pkg::SH_W'(gp_s12) << side_s12.shift) + gpl_pkg::FINAL_BIAS;
		v  = sh[gpl_pkg::SH_W-1:30];
		if (side_s12.zero)
			pix_nxt = '0;
		else if (side_s12.big)
			pix_nxt = (gain_q != '0) ? gpl_pkg::PIX_MAX : '0;
		else if (v > gpl_pkg::V_W'(gpl_pkg::PIX_MAX))
			pix_nxt = gpl_pkg::PIX_MAX;
		else
			pix_nxt = v[gpl_pkg::PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s12)
				valid_s12 <= ex_valid;
			if (en_s13)
				valid_s13 <= valid_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			log_s1  <= gpl_pkg::LOG2_TAB[pixel_in];
			zero_s1 <= (pixel_in == '0);
		end
		if (en_s2) begin
			frac_s2 <= p[gpl_pkg::FRAC_W-1:0];
			side_s2 <= side_nxt;
		end
		if (en_s12) begin
			gp_s12   <= gpl_pkg::GP_W'(gain_q) * gpl_pkg::GP_W'(ex_r);
			side_s12 <= ex_side;
		end
		if (en_s13)
			pix_s13 <= pix_nxt;
	end

	gpl_exp2 u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_stall  (ex_stall),
		.in_frac   (frac_s2),
		.in_side   (side_s2),
		.out_valid (ex_valid),
		.out_stall (!en_s12),
		.out_r     (ex_r),
		.out_side  (ex_side)
	);

	assign out_valid = valid_s13;
	assign pixel_out = pix_s13;

	a_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s13 && valid_s12 && side_s12.zero) |=> (pixel_out == '0))
		else $error("zero pixel did not give zero");

	a_big_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s13 && valid_s12 && !side_s12.zero && side_s12.big && gain_q != '0)
		|=> (pixel_out == gpl_pkg::PIX_MAX))
		else $error("large exponent did not saturate");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

endmodule

`default_nettype wire

// File: sv/gpl_exp2.sv
// gpl_exp2: pipelined 2^f for a 16-bit fraction, Q1.30 result
// table stage for the upper byte, then one multiply stage per lower fraction bit; uses gpl_pkg
`default_nettype none

module gpl_exp2 (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [gpl_pkg::FRAC_W-1:0]   in_frac,
	input  wire gpl_pkg::side_t               in_side,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [gpl_pkg::Q_W-1:0]           out_r,
	output gpl_pkg::side_t                    out_side
);

	localparam int NS = gpl_pkg::LO_W + 1;

	logic                         valid_s [NS];
	logic [gpl_pkg::Q_W-1:0]      r_s     [NS];
	logic [gpl_pkg::LO_W-1:0]     lo_s    [NS];
	gpl_pkg::side_t               side_s  [NS];
	logic                         en      [NS];
	logic [gpl_pkg::Q_W-1:0]      r_nxt   [gpl_pkg::LO_W];

	always_comb begin
		en[NS-1] = !valid_s[NS-1] || !out_stall;
		for (int i = NS - 2; i >= 0; i--)
			en[i] = !valid_s[i] || en[i+1];
	end

	always_comb begin
		logic [2*gpl_pkg::Q_W-1:0] prod;
		for (int j = 0; j < gpl_pkg::LO_W; j++) begin
			prod = (2*gpl_pkg::Q_W)'(r_s[j]) *
				(2*gpl_pkg::Q_W)'(gpl_pkg::EXP_C[gpl_pkg::HI_W + 1 + j]);
			r_nxt[j] = lo_s[j][gpl_pkg::LO_W-1-j] ? prod[gpl_pkg::Q_W+29:30] : r_s[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++)
				valid_s[i] <= 1'b0;
		end else begin
			if (en[0])
				valid_s[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (en[i])
					valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s[0]    <= gpl_pkg::EXP_HI_TAB[in_frac[gpl_pkg::FRAC_W-1:gpl_pkg::LO_W]];
			lo_s[0]   <= in_frac[gpl_pkg::LO_W-1:0];
			side_s[0] <= in_side;
		end
		for (int i = 1; i < NS; i++) begin
			if (en[i]) begin
				r_s[i]    <= r_nxt[i-1];
				lo_s[i]   <= lo_s[i-1];
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = valid_s[NS-1];
	assign out_r     = r_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

`default_nettype wire
